// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, edge codes and request/result types for the rectangle /
// segment intersection unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIF_W      = COORD_BITS + 1;
    localparam int PRD_W      = 2 * COORD_BITS + 2;
    localparam int SUM_W      = 2 * COORD_BITS + 3;
    localparam int OUT_W      = 24;
    localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_W - 1));

    typedef logic [1:0] edge_t;

    localparam edge_t EDGE_LEFT   = 2'd0;
    localparam edge_t EDGE_RIGHT  = 2'd1;
    localparam edge_t EDGE_BOTTOM = 2'd2;
    localparam edge_t EDGE_TOP    = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_top;
        logic signed [COORD_BITS-1:0] rect_right;
        logic signed [COORD_BITS-1:0] rect_bottom;
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
    } query_t;

    typedef struct packed {
        logic                    hit;
        edge_t                   edge_hit;
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
    } result_t;

    // cross products of the left, right, bottom and top edges, ready for the range tests
    typedef struct packed {
        logic signed [SUM_W-1:0]      den_v;
        logic signed [SUM_W-1:0]      den_h;
        logic signed [SUM_W-1:0]      ta_l;
        logic signed [SUM_W-1:0]      ta_r;
        logic signed [SUM_W-1:0]      ta_b;
        logic signed [SUM_W-1:0]      tb_l;
        logic signed [SUM_W-1:0]      tb_r;
        logic signed [SUM_W-1:0]      tb_b;
        logic signed [SUM_W-1:0]      tb_t;
        logic signed [SUM_W-1:0]      num_vl;
        logic signed [SUM_W-1:0]      num_vr;
        logic signed [SUM_W-1:0]      num_hb;
        logic signed [SUM_W-1:0]      num_ht;
        logic signed [DIF_W-1:0]      dx;
        logic signed [DIF_W-1:0]      dy;
        logic signed [COORD_BITS-1:0] l;
        logic signed [COORD_BITS-1:0] r;
        logic signed [COORD_BITS-1:0] b;
        logic signed [COORD_BITS-1:0] t;
    } front_t;

    // travels alongside the divider
    typedef struct packed {
        logic                    hit;
        edge_t                   edge_sel;
        logic                    vert;
        logic                    neg;
        logic [DIF_W-1:0]        div_mag;
        logic signed [OUT_W-1:0] fix_val;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [SUM_W-1:0] num_mag;
    } seed_t;

endpackage

// ===== sv/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front
// Three stages: coordinate differences, products, cross-product sums.
// ----------------------------------------------------------------------------
module rsi_front
    import rsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   query_valid,
    input  query_t query,
    output logic   front_valid,
    output front_t front
);

    logic                         v1_reg, v2_reg, v3_reg;
    logic signed [DIF_W-1:0]      dx_reg, dy_reg, h_reg, wd_reg;
    logic signed [DIF_W-1:0]      wxl_reg, wxr_reg, wyb_reg, wyt_reg;
    logic signed [COORD_BITS-1:0] l1_reg, r1_reg, b1_reg, t1_reg, sx_reg, sy_reg;

    logic signed [PRD_W-1:0]      p_dxwyt_reg, p_dxwyb_reg, p_dywxl_reg, p_dywxr_reg;
    logic signed [PRD_W-1:0]      p_dxh_reg, p_dywd_reg, p_hwxl_reg, p_hwxr_reg;
    logic signed [PRD_W-1:0]      p_wdwyb_reg, p_wdwyt_reg, p_sydx_reg, p_sxdy_reg;
    logic signed [DIF_W-1:0]      dx2_reg, dy2_reg;
    logic signed [COORD_BITS-1:0] l2_reg, r2_reg, b2_reg, t2_reg;

    front_t                       front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= query_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // differences; left edge starts at (L,T), bottom at (L,B)
            dx_reg  <= DIF_W'(query.seg_end_x) - DIF_W'(query.seg_start_x);
            dy_reg  <= DIF_W'(query.seg_end_y) - DIF_W'(query.seg_start_y);
            h_reg   <= DIF_W'(query.rect_bottom) - DIF_W'(query.rect_top);
            wd_reg  <= DIF_W'(query.rect_right) - DIF_W'(query.rect_left);
            wxl_reg <= DIF_W'(query.rect_left) - DIF_W'(query.seg_start_x);
            wxr_reg <= DIF_W'(query.rect_right) - DIF_W'(query.seg_start_x);
            wyb_reg <= DIF_W'(query.rect_bottom) - DIF_W'(query.seg_start_y);
            wyt_reg <= DIF_W'(query.rect_top) - DIF_W'(query.seg_start_y);
            l1_reg  <= query.rect_left;
            r1_reg  <= query.rect_right;
            b1_reg  <= query.rect_bottom;
            t1_reg  <= query.rect_top;
            sx_reg  <= query.seg_start_x;
            sy_reg  <= query.seg_start_y;

            p_dxwyt_reg <= PRD_W'(dx_reg) * PRD_W'(wyt_reg);
            p_dxwyb_reg <= PRD_W'(dx_reg) * PRD_W'(wyb_reg);
            p_dywxl_reg <= PRD_W'(dy_reg) * PRD_W'(wxl_reg);
            p_dywxr_reg <= PRD_W'(dy_reg) * PRD_W'(wxr_reg);
            p_dxh_reg   <= PRD_W'(dx_reg) * PRD_W'(h_reg);
            p_dywd_reg  <= PRD_W'(dy_reg) * PRD_W'(wd_reg);
            p_hwxl_reg  <= PRD_W'(h_reg) * PRD_W'(wxl_reg);
            p_hwxr_reg  <= PRD_W'(h_reg) * PRD_W'(wxr_reg);
            p_wdwyb_reg <= PRD_W'(wd_reg) * PRD_W'(wyb_reg);
            p_wdwyt_reg <= PRD_W'(wd_reg) * PRD_W'(wyt_reg);
            p_sydx_reg  <= PRD_W'(sy_reg) * PRD_W'(dx_reg);
            p_sxdy_reg  <= PRD_W'(sx_reg) * PRD_W'(dy_reg);
            dx2_reg     <= dx_reg;
            dy2_reg     <= dy_reg;
            l2_reg      <= l1_reg;
            r2_reg      <= r1_reg;
            b2_reg      <= b1_reg;
            t2_reg      <= t1_reg;

            // top edge shares ta with the left edge (same start point)
            front_reg.den_v  <= -SUM_W'(p_dxh_reg);
            front_reg.den_h  <= SUM_W'(p_dywd_reg);
            front_reg.ta_l   <= SUM_W'(p_dxwyt_reg) - SUM_W'(p_dywxl_reg);
            front_reg.ta_r   <= SUM_W'(p_dxwyt_reg) - SUM_W'(p_dywxr_reg);
            front_reg.ta_b   <= SUM_W'(p_dxwyb_reg) - SUM_W'(p_dywxl_reg);
            front_reg.tb_l   <= -SUM_W'(p_hwxl_reg);
            front_reg.tb_r   <= -SUM_W'(p_hwxr_reg);
            front_reg.tb_b   <= SUM_W'(p_wdwyb_reg);
            front_reg.tb_t   <= SUM_W'(p_wdwyt_reg);
            front_reg.num_vl <= SUM_W'(p_sydx_reg) + SUM_W'(p_dywxl_reg);
            front_reg.num_vr <= SUM_W'(p_sydx_reg) + SUM_W'(p_dywxr_reg);
            front_reg.num_hb <= SUM_W'(p_sxdy_reg) + SUM_W'(p_dxwyb_reg);
            front_reg.num_ht <= SUM_W'(p_sxdy_reg) + SUM_W'(p_dxwyt_reg);
            front_reg.dx     <= dx2_reg;
            front_reg.dy     <= dy2_reg;
            front_reg.l      <= l2_reg;
            front_reg.r      <= r2_reg;
            front_reg.b      <= b2_reg;
            front_reg.t      <= t2_reg;
        end
    end

    assign front_valid = v3_reg;
    assign front       = front_reg;

endmodule

// ===== sv/rsi_edge.sv =====
// ----------------------------------------------------------------------------
// rsi_edge
// Two stages: range test of every edge, then first-hit selection and the
// sign/magnitude split that feeds the divider.
// ----------------------------------------------------------------------------
module rsi_edge
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   front_valid,
    input  front_t front,
    output logic   seed_valid,
    output seed_t  seed
);

    localparam int XW = ((COORD_BITS + FRAC_BITS > OUT_W) ? COORD_BITS + FRAC_BITS : OUT_W) + 1;
    localparam logic signed [XW-1:0] XMAX = XW'(OUT_MAX);
    localparam logic signed [XW-1:0] XMIN = XW'(OUT_MIN);

    // both parameters in [0,1], den != 0, not both numerators zero
    function automatic logic edge_ok(input logic signed [SUM_W-1:0] den,
                                     input logic signed [SUM_W-1:0] ta,
                                     input logic signed [SUM_W-1:0] tb);
        logic ta_z, tb_z, inr;
        ta_z = (ta == den - den);
        tb_z = (tb == den - den);
        if (!den[SUM_W-1])
            inr = !ta[SUM_W-1] && (ta <= den) && !tb[SUM_W-1] && (tb <= den);
        else
            inr = (ta[SUM_W-1] || ta_z) && (ta >= den) && (tb[SUM_W-1] || tb_z) && (tb >= den);
        return (den != den - den) && !(ta_z && tb_z) && inr;
    endfunction

    logic        v4_reg, v5_reg;
    logic [3:0]  hit4_reg;
    front_t      fr4_reg;
    seed_t       seed_reg;

    logic                         sel_hit, sel_vert;
    edge_t                        sel_edge;
    logic signed [SUM_W-1:0]      sel_num;
    logic signed [DIF_W-1:0]      sel_div;
    logic signed [COORD_BITS-1:0] sel_fix;
    logic signed [XW-1:0]         fix_ext;
    logic signed [OUT_W-1:0]      fix_sat;

    always_comb
    begin
        sel_hit  = 1'b1;
        sel_vert = 1'b1;
        sel_edge = EDGE_LEFT;
        sel_num  = fr4_reg.num_vl;
        sel_div  = fr4_reg.dx;
        sel_fix  = fr4_reg.l;
        if (hit4_reg[0])
        begin
            sel_edge = EDGE_LEFT;
        end
        else if (hit4_reg[1])
        begin
            sel_edge = EDGE_RIGHT;
            sel_num  = fr4_reg.num_vr;
            sel_fix  = fr4_reg.r;
        end
        else if (hit4_reg[2])
        begin
            sel_edge = EDGE_BOTTOM;
            sel_vert = 1'b0;
            sel_num  = fr4_reg.num_hb;
            sel_div  = fr4_reg.dy;
            sel_fix  = fr4_reg.b;
        end
        else if (hit4_reg[3])
        begin
            sel_edge = EDGE_TOP;
            sel_vert = 1'b0;
            sel_num  = fr4_reg.num_ht;
            sel_div  = fr4_reg.dy;
            sel_fix  = fr4_reg.t;
        end
        else
        begin
            sel_hit = 1'b0;
        end

        fix_ext = XW'(sel_fix) <<< FRAC_BITS;
        if (fix_ext > XMAX)
            fix_sat = OUT_W'(XMAX);
        else if (fix_ext < XMIN)
            fix_sat = OUT_W'(XMIN);
        else
            fix_sat = fix_ext[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= front_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit4_reg[0] <= edge_ok(front.den_v, front.ta_l, front.tb_l);
            hit4_reg[1] <= edge_ok(front.den_v, front.ta_r, front.tb_r);
            hit4_reg[2] <= edge_ok(front.den_h, front.ta_b, front.tb_b);
            hit4_reg[3] <= edge_ok(front.den_h, front.ta_l, front.tb_t);
            fr4_reg     <= front;

            seed_reg.tag.hit      <= sel_hit;
            seed_reg.tag.edge_sel <= sel_edge;
            seed_reg.tag.vert     <= sel_vert;
            seed_reg.tag.neg      <= sel_num[SUM_W-1] ^ sel_div[DIF_W-1];
            seed_reg.tag.div_mag  <= sel_div[DIF_W-1] ? DIF_W'(-sel_div) : DIF_W'(sel_div);
            seed_reg.tag.fix_val  <= fix_sat;
            seed_reg.num_mag      <= sel_num[SUM_W-1] ? SUM_W'(-sel_num) : SUM_W'(sel_num);
        end
    end

    assign seed_valid = v5_reg;
    assign seed       = seed_reg;

endmodule

// ===== sv/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// floor(num_mag * 2^FRAC_BITS / div_mag); the point lies on the segment so
// the quotient fits COORD_BITS + FRAC_BITS bits.
// ----------------------------------------------------------------------------
module rsi_div
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   seed_valid,
    input  seed_t  seed,
    output logic   quot_valid,
    output tag_t   quot_tag,
    output logic [COORD_BITS+FRAC_BITS-1:0] quot
);

    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int NW = SUM_W + FRAC_BITS;
    localparam int RW = DIF_W + 1;

    logic [NW-1:0]    dividend;
    logic             vld_reg [QW];
    logic [DIF_W-1:0] rem_reg [QW];
    logic [QW-1:0]    qn_reg  [QW];
    tag_t             tag_reg [QW];

    assign dividend = NW'(seed.num_mag) << FRAC_BITS;

    generate
        for (genvar g = 0; g < QW; g++)
        begin : g_stage
            logic             vld_in;
            logic [DIF_W-1:0] rem_in;
            logic [QW-1:0]    qn_in;
            tag_t             tag_in;
            logic [RW-1:0]    trial;
            logic [RW-1:0]    diff;
            logic             ge;

            if (g == 0)
            begin : g_first
                // top part is below the divisor, as the quotient fits QW bits
                assign vld_in = seed_valid;
                assign rem_in = dividend[QW+DIF_W-1:QW];
                assign qn_in  = dividend[QW-1:0];
                assign tag_in = seed.tag;
            end
            else
            begin : g_next
                assign vld_in = vld_reg[g-1];
                assign rem_in = rem_reg[g-1];
                assign qn_in  = qn_reg[g-1];
                assign tag_in = tag_reg[g-1];
            end

            assign trial = {rem_in, qn_in[QW-1]};
            assign diff  = trial - {1'b0, tag_in.div_mag};
            assign ge    = (trial >= {1'b0, tag_in.div_mag});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (adv)
                    vld_reg[g] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g] <= ge ? diff[DIF_W-1:0] : trial[DIF_W-1:0];
                    qn_reg[g]  <= {qn_in[QW-2:0], ge};
                    tag_reg[g] <= tag_in;
                end
            end
        end
    endgenerate

    assign quot_valid = vld_reg[QW-1];
    assign quot_tag   = tag_reg[QW-1];
    assign quot       = qn_reg[QW-1];

endmodule

// ===== sv/rect_segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// rect_segment_intersection_unit
// Tests an axis-aligned rectangle against a line segment and reports the
// first edge crossed in the order left, right, bottom, top, and the crossing point.
// ----------------------------------------------------------------------------
// Use:
//   A request on query (query_valid / query_stall) carries the rectangle and
//   segment; one result per request leaves on result (result_valid /
//   result_stall), in request order. cross_x / cross_y are signed fixed
//   point with FRAC_BITS fraction bits, truncated toward zero and saturated
//   to 24 bits; with no hit, edge_hit and both coordinates are zero.
//   The pipeline has three stages of differences, products and sums, two of
//   edge test and selection, one per quotient bit in the divider, and one
//   output register. A new request is taken every cycle while query_stall
//   is low. The whole pipeline advances as one;
//   while result_valid is high and result_stall is asserted it holds, and
//   query_stall is raised so no request is dropped or repeated.
//   Reset clears all valid bits; no results are pending after reset.
// ----------------------------------------------------------------------------
module rect_segment_intersection_unit
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_stall,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int QW = COORD_BITS + FRAC_BITS;
    localparam int SW = ((QW > OUT_W) ? QW : OUT_W) + 1;
    localparam logic [SW-1:0] POS_LIM = SW'(OUT_MAX);
    localparam logic [SW-1:0] NEG_LIM = SW'(OUT_MAX + 1);
    localparam logic signed [OUT_W-1:0] SAT_MAX = OUT_W'(OUT_MAX);
    localparam logic signed [OUT_W-1:0] SAT_MIN = OUT_W'(OUT_MIN);

    logic    adv;
    logic    front_valid, seed_valid, quot_valid;
    front_t  front;
    seed_t   seed;
    tag_t    quot_tag;
    logic [QW-1:0] quot;

    logic                    result_valid_reg;
    result_t                 result_reg;
    logic [SW-1:0]           mag_x, neg_x;
    logic signed [OUT_W-1:0] div_val;
    result_t                 result_next;

    assign adv         = !result_valid_reg || !result_stall;
    assign query_stall = !adv;

    rsi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .query_valid (query_valid),
        .query       (query),
        .front_valid (front_valid),
        .front       (front)
    );

    rsi_edge #(.FRAC_BITS(FRAC_BITS)) u_edge (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .front_valid (front_valid),
        .front       (front),
        .seed_valid  (seed_valid),
        .seed        (seed)
    );

    rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .seed_valid (seed_valid),
        .seed       (seed),
        .quot_valid (quot_valid),
        .quot_tag   (quot_tag),
        .quot       (quot)
    );

    assign mag_x = SW'(quot);
    assign neg_x = SW'(0) - mag_x;

    always_comb
    begin
        if (quot_tag.neg)
            div_val = (mag_x > NEG_LIM) ? SAT_MIN : neg_x[OUT_W-1:0];
        else
            div_val = (mag_x > POS_LIM) ? SAT_MAX : mag_x[OUT_W-1:0];

        result_next.hit      = quot_tag.hit;
        result_next.edge_hit = EDGE_LEFT;
        result_next.cross_x  = '0;
        result_next.cross_y  = '0;
        if (quot_tag.hit)
        begin
            result_next.edge_hit = quot_tag.edge_sel;
            result_next.cross_x  = quot_tag.vert ? quot_tag.fix_val : div_val;
            result_next.cross_y  = quot_tag.vert ? div_val : quot_tag.fix_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= quot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the rectangle / segment intersection unit against an exact integer
// predictor: directed corner cases, then random queries under idle and stall phases.
// ----------------------------------------------------------------------------
module testbench
    import rsi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam longint CYCLE_LIMIT = 400000;

    class crossing_board;
        result_t pending[$];
        int      errors;
        int      mism;

        function longint fixdiv(longint num, longint den);
            bit neg;
            longint n, d, mag;
            neg = 1'b0;
            n = num;
            d = den;
            if (n < 0) begin neg = 1'b1; n = -n; end
            if (d < 0) begin neg = !neg; d = -d; end
            mag = ((n / d) << FRAC) + (((n % d) << FRAC) / d);
            if (neg) begin
                if (mag > longint'(OUT_MAX) + 1) return OUT_MIN;
                return -mag;
            end
            if (mag > OUT_MAX) return OUT_MAX;
            return mag;
        endfunction

        function bit edge_cross(longint p1x, longint p1y, longint p2x, longint p2y,
                                longint sx, longint sy, longint qx, longint qy,
                                output longint ox, output longint oy);
            longint d1x, d1y, d2x, d2y, wx, wy, den, ta, tb;
            d1x = p2x - p1x; d1y = p2y - p1y;
            d2x = qx - sx;   d2y = qy - sy;
            wx = p1x - sx;   wy = p1y - sy;
            den = d2y * d1x - d2x * d1y;
            ox = 0; oy = 0;
            if (den == 0) return 1'b0;
            ta = d2x * wy - d2y * wx;
            tb = d1x * wy - d1y * wx;
            if (ta == 0 && tb == 0) return 1'b0;
            if (den < 0) begin den = -den; ta = -ta; tb = -tb; end
            if (ta < 0 || ta > den || tb < 0 || tb > den) return 1'b0;
            if (d1x == 0) begin
                ox = fixdiv(p1x, 1);
                oy = fixdiv(sy * d2x + wx * d2y, d2x);
            end
            else begin
                ox = fixdiv(sx * d2y + wy * d2x, d2y);
                oy = fixdiv(p1y, 1);
            end
            return 1'b1;
        endfunction

        function void note_query(query_t q);
            longint l, t, r, b, sx, sy, qx, qy, px, py;
            result_t e;
            l = q.rect_left; t = q.rect_top; r = q.rect_right; b = q.rect_bottom;
            sx = q.seg_start_x; sy = q.seg_start_y; qx = q.seg_end_x; qy = q.seg_end_y;
            e = '0;
            if (edge_cross(l, t, l, b, sx, sy, qx, qy, px, py)) begin
                e.hit = 1'b1; e.edge_hit = EDGE_LEFT;
            end
            else if (edge_cross(r, t, r, b, sx, sy, qx, qy, px, py)) begin
                e.hit = 1'b1; e.edge_hit = EDGE_RIGHT;
            end
            else if (edge_cross(l, b, r, b, sx, sy, qx, qy, px, py)) begin
                e.hit = 1'b1; e.edge_hit = EDGE_BOTTOM;
            end
            else if (edge_cross(l, t, r, t, sx, sy, qx, qy, px, py)) begin
                e.hit = 1'b1; e.edge_hit = EDGE_TOP;
            end
            if (e.hit) begin
                e.cross_x = px[OUT_W-1:0];
                e.cross_y = py[OUT_W-1:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit || got.edge_hit !== e.edge_hit ||
                got.cross_x !== e.cross_x || got.cross_y !== e.cross_y) begin
                errors++;
                if (mism++ < 10)
                    $display({"mismatch: exp hit %0d edge %0d x %0d y %0d,",
                              " got hit %0d edge %0d x %0d y %0d"},
                             e.hit, e.edge_hit, e.cross_x, e.cross_y,
                             got.hit, got.edge_hit, got.cross_x, got.cross_y);
            end
        endfunction
    endclass

    logic    clk = 0;
    logic    rst_n = 0;
    logic    query_valid = 0;
    logic    query_stall;
    query_t  query = '0;
    logic    result_valid;
    logic    result_stall = 0;
    result_t result;

    crossing_board board = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    longint cycles = 0;

    rect_segment_intersection_unit #(.FRAC_BITS(FRAC)) u_dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink: check accepted results, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall) board.check_result(result);
            result_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    task automatic send_query(query_t q);
        while ($urandom_range(99) < send_idle)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        query <= q;
        @(posedge clk);
        while (query_stall) @(posedge clk);
        board.note_query(q);
    endtask

    task automatic rest_source();
        query_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rcoord();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic query_t make_query(int k);
        query_t q;
        int l, r, b, t;
        q = {$urandom, $urandom, $urandom, $urandom};
        if (k < 2) return q;
        if (k < 4)
        begin
            q.rect_left = rcoord(); q.rect_top = rcoord();
            q.rect_right = rcoord(); q.rect_bottom = rcoord();
            q.seg_start_x = rcoord(); q.seg_start_y = rcoord();
            q.seg_end_x = rcoord(); q.seg_end_y = rcoord();
            return q;
        end
        // well-formed box with segment running through its neighbourhood
        l = int'($urandom_range(60000)) - 30000;
        r = l + int'($urandom_range(2000));
        b = int'($urandom_range(60000)) - 30000;
        t = b + int'($urandom_range(2000));
        if ($urandom_range(1)) begin q.rect_top = 16'(t); q.rect_bottom = 16'(b); end
        else begin q.rect_top = 16'(b); q.rect_bottom = 16'(t); end
        q.rect_left = 16'(l); q.rect_right = 16'(r);
        q.seg_start_x = 16'(l + int'($urandom_range(3000)) - 500);
        q.seg_start_y = 16'(b + int'($urandom_range(3000)) - 500);
        q.seg_end_x = 16'(l + int'($urandom_range(3000)) - 500);
        q.seg_end_y = 16'(b + int'($urandom_range(3000)) - 500);
        if ($urandom_range(7) == 0) q.seg_end_x = q.seg_start_x;
        if ($urandom_range(7) == 0) q.seg_end_y = q.seg_start_y;
        return q;
    endfunction

    query_t q;
    int phase;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: crossings of each edge, parallels, collinear, extremes, corner
        send_query('{-10, 10, 10, -10, -20, 0, 0, 0});
        send_query('{-10, 10, 10, -10, 20, 3, 0, 3});
        send_query('{-10, 10, 10, -10, 1, -20, 1, 0});
        send_query('{-10, 10, 10, -10, -3, 20, -3, 0});
        send_query('{-10, 10, 10, -10, -10, -20, -10, 20});
        send_query('{-10, 10, 10, -10, -20, 10, 20, 10});
        send_query('{-10, 10, 10, -10, -20, -20, 20, 20});
        send_query('{-10, 10, 10, -10, 3, 3, 3, 3});
        send_query('{-10, 10, 10, -10, 0, 0, 1, 7});
        send_query('{0, 0, 0, 0, -5, -5, 5, 5});
        send_query('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767});
        send_query('{-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767});
        send_query('{32767, -32768, -32768, 32767, -32768, 1, 32767, 0});
        send_query('{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767});
        send_query('{-1, 1, 1, -1, -32768, 32767, 32767, -32767});
        send_query('{0, 3, 7, 0, 0, 0, 7, 1});
        send_query('{0, 3, 7, 0, -1, 1, 2, 2});
        send_query('1);
        send_query('0);
        rest_source();
        // pause until every expected result has come
        while (board.pending.size() != 0) @(posedge clk);
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle  = (phase == 1 || phase == 3) ? (phase == 1 ? 53 : 20) : 0;
            recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 53 : 20) : 0;
            repeat (460)
            begin
                q = make_query($urandom_range(9));
                send_query(q);
            end
        end
        rest_source();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
